// File: rtl/core/fdwm_pkg.sv
`timescale 1ns / 1ps

package fdwm_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_DELAY_LENGTH  = 2'd0,
		CFG_FEEDBACK_GAIN = 2'd1,
		CFG_DRY_GAIN      = 2'd2,
		CFG_WET_GAIN      = 2'd3
	} cfg_idx_t;

	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 25;
	localparam int DELAY_W      = 25;
	localparam int GAIN_W       = 16;

	localparam logic [DELAY_W-1:0] DELAY_RST = 25'd4915200;
	localparam logic [GAIN_W-1:0]  FB_RST    = 16'd22938;
	localparam logic [GAIN_W-1:0]  DRY_RST   = 16'd27939;
	localparam logic [GAIN_W-1:0]  WET_RST   = 16'd17121;

	localparam logic [DELAY_W-1:0] DELAY_MIN = 25'd256;
	localparam logic [GAIN_W-1:0]  FB_CAP    = 16'd62259;
	localparam logic [GAIN_W-1:0]  GAIN_CAP  = 16'd32768;

	// sequencer, one-hot
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD1  = 10'b00_0000_0010,
		ST_RD2  = 10'b00_0000_0100,
		ST_V2   = 10'b00_0000_1000,
		ST_M1   = 10'b00_0001_0000,
		ST_D    = 10'b00_0010_0000,
		ST_M2   = 10'b00_0100_0000,
		ST_FB   = 10'b00_1000_0000,
		ST_M4   = 10'b01_0000_0000,
		ST_MIX  = 10'b10_0000_0000
	} state_t;

endpackage

// File: rtl/core/feedback_delay_wet_dry_mix_top.sv
`timescale 1ns / 1ps

// One sample at a time: a sample is accepted only in ST_IDLE, then the sequencer steps
// RD1, RD2, V2, M1, D, M2, FB, M4 and MIX, which waits for a free output slot; the single
// shared multiplier and the one read port of the delay RAM are stepped through in turn.
// Reset: arst_n asynchronous, active low; write pointers, fill counts and config registers
// return to defaults. Delay RAM is not swept: unwritten taps read as zero via fill counts.
module feedback_delay_wet_dry_mix_top #(
	parameter int MAX_DELAY   = 131072,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [fdwm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [fdwm_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample_in
	input  logic                              s_axis_tuser,  // channel

	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata   // sample_out
);

	localparam int SB      = SAMPLE_BITS;
	localparam int DW      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW      = $clog2(MAX_DELAY);
	localparam int RAW     = AW + ((CHANNELS > 1) ? 1 : 0);
	localparam int PW      = SB + 18;
	localparam int DLW     = (AW + 8 > fdwm_pkg::DELAY_W) ? AW + 8 : fdwm_pkg::DELAY_W;

	localparam logic [DLW-1:0] DL_MIN = DLW'(fdwm_pkg::DELAY_MIN);
	localparam logic [DLW-1:0] DL_MAX = DLW'((MAX_DELAY - 1) * 256);
	localparam logic [AW:0]    MD     = (AW + 1)'(MAX_DELAY);

	localparam logic signed [PW-1:0] SAT_HI = {{(PW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [PW-1:0] RND8   = PW'(128);
	localparam logic signed [PW-1:0] RND15  = PW'(16384);
	localparam logic signed [PW-1:0] RND16  = PW'(32768);

	// configuration
	logic [fdwm_pkg::DELAY_W-1:0] delay_length_q;
	logic [fdwm_pkg::GAIN_W-1:0]  feedback_gain_q;
	logic [fdwm_pkg::GAIN_W-1:0]  dry_gain_q;
	logic [fdwm_pkg::GAIN_W-1:0]  wet_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q  <= fdwm_pkg::DELAY_RST;
			feedback_gain_q <= fdwm_pkg::FB_RST;
			dry_gain_q      <= fdwm_pkg::DRY_RST;
			wet_gain_q      <= fdwm_pkg::WET_RST;
		end else if (cfg_we) begin
			case (fdwm_pkg::cfg_idx_t'(cfg_addr))
				fdwm_pkg::CFG_DELAY_LENGTH:  delay_length_q  <= cfg_data;
				fdwm_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[fdwm_pkg::GAIN_W-1:0];
				fdwm_pkg::CFG_DRY_GAIN:      dry_gain_q      <= cfg_data[fdwm_pkg::GAIN_W-1:0];
				fdwm_pkg::CFG_WET_GAIN:      wet_gain_q      <= cfg_data[fdwm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped operating values, taken at accept
	logic [DLW-1:0]                dl_ext;
	logic [DLW-1:0]                dl_c;
	logic [fdwm_pkg::GAIN_W-1:0]   fb_c;
	logic [fdwm_pkg::GAIN_W-1:0]   dg_c;
	logic [fdwm_pkg::GAIN_W-1:0]   wg_c;

	always_comb begin
		dl_ext = DLW'(delay_length_q);
		if (dl_ext < DL_MIN) begin
			dl_c = DL_MIN;
		end else if (dl_ext > DL_MAX) begin
			dl_c = DL_MAX;
		end else begin
			dl_c = dl_ext;
		end
		fb_c = (feedback_gain_q > fdwm_pkg::FB_CAP)  ? fdwm_pkg::FB_CAP   : feedback_gain_q;
		dg_c = (dry_gain_q      > fdwm_pkg::GAIN_CAP) ? fdwm_pkg::GAIN_CAP : dry_gain_q;
		wg_c = (wet_gain_q      > fdwm_pkg::GAIN_CAP) ? fdwm_pkg::GAIN_CAP : wet_gain_q;
	end

	fdwm_pkg::state_t state_q;

	logic                         ch_q;
	logic signed [SB-1:0]         dry_q;
	logic [AW-1:0]                di_q;
	logic [7:0]                   fr_q;
	logic [fdwm_pkg::GAIN_W-1:0]  fb_q;
	logic [fdwm_pkg::GAIN_W-1:0]  dg_q;
	logic [fdwm_pkg::GAIN_W-1:0]  wg_q;

	logic [AW-1:0]                wp_q   [CHANNELS];
	logic [AW:0]                  fill_q [CHANNELS];

	logic                         vld1_q;
	logic                         vld2_q;
	logic signed [SB-1:0]         v1_q;
	logic signed [SB:0]           diff_q;
	logic signed [SB-1:0]         d_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [PW-1:0]         acc_q;

	logic                         out_valid_q;
	logic [SB-1:0]                out_q;

	logic                         in_fire;
	assign s_axis_tready = (state_q == fdwm_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	// tap address: age di for the newer tap, di+1 for the older one
	logic [AW-1:0]  wp_cur;
	logic [AW:0]    fill_cur;
	logic [AW:0]    age;
	logic [AW:0]    pos_t;
	logic [AW-1:0]  pos;
	logic           tap_vld;

	always_comb begin
		wp_cur   = wp_q[ch_q];
		fill_cur = fill_q[ch_q];
		age      = (state_q == fdwm_pkg::ST_RD1) ? {1'b0, di_q} : {1'b0, di_q} + 1'b1;
		pos_t    = {1'b0, wp_cur} - age;
		if ({1'b0, wp_cur} < age) begin
			pos_t = pos_t + MD;
		end
		pos     = pos_t[AW-1:0];
		tap_vld = (fill_cur >= age);
	end

	// shared multiplier operand select
	logic signed [SB:0]   mul_a;
	logic signed [16:0]   mul_b;

	always_comb begin
		case (state_q)
			fdwm_pkg::ST_M1: begin
				mul_a = diff_q;
				mul_b = {9'b0, fr_q};
			end
			fdwm_pkg::ST_M2: begin
				mul_a = (SB + 1)'(d_q);
				mul_b = {1'b0, fb_q};
			end
			fdwm_pkg::ST_FB: begin
				mul_a = (SB + 1)'(dry_q);
				mul_b = {1'b0, dg_q};
			end
			default: begin
				mul_a = (SB + 1)'(d_q);
				mul_b = {1'b0, wg_q};
			end
		endcase
	end

	// datapath results
	logic signed [SB-1:0]  rd_s;
	logic signed [PW-1:0]  interp;
	logic signed [PW-1:0]  stored_w;
	logic signed [PW-1:0]  mixed_w;
	logic [SB-1:0]         stored_sat;
	logic [SB-1:0]         mixed_sat;
	logic [SB-1:0]         rdata;

	always_comb begin
		rd_s     = $signed(rdata);
		interp   = PW'(v1_q) + ((prod_q + RND8) >>> 8);
		stored_w = PW'(dry_q) + ((prod_q + RND16) >>> 16);
		mixed_w  = (acc_q + prod_q + RND15) >>> 15;
		if (stored_w > SAT_HI) begin
			stored_sat = SAT_HI[SB-1:0];
		end else if (stored_w < SAT_LO) begin
			stored_sat = SAT_LO[SB-1:0];
		end else begin
			stored_sat = stored_w[SB-1:0];
		end
		if (mixed_w > SAT_HI) begin
			mixed_sat = SAT_HI[SB-1:0];
		end else if (mixed_w < SAT_LO) begin
			mixed_sat = SAT_LO[SB-1:0];
		end else begin
			mixed_sat = mixed_w[SB-1:0];
		end
	end

	logic            ram_we;
	logic [RAW-1:0]  ram_waddr;
	logic [RAW-1:0]  ram_raddr;
	logic [AW:0]     waddr_full;
	logic [AW:0]     raddr_full;

	assign ram_we     = (state_q == fdwm_pkg::ST_FB);
	assign waddr_full = {ch_q, wp_cur};
	assign raddr_full = {ch_q, pos};
	assign ram_waddr  = waddr_full[RAW-1:0];
	assign ram_raddr  = raddr_full[RAW-1:0];

	fdwm_ram #(
		.WIDTH (SB),
		.DEPTH (1 << RAW)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (stored_sat),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// sequencer and per-channel pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdwm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]   <= '0;
				fill_q[c] <= '0;
			end
		end else begin
			if (state_q == fdwm_pkg::ST_MIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fdwm_pkg::ST_IDLE: if (in_fire) state_q <= fdwm_pkg::ST_RD1;
				fdwm_pkg::ST_RD1:  state_q <= fdwm_pkg::ST_RD2;
				fdwm_pkg::ST_RD2:  state_q <= fdwm_pkg::ST_V2;
				fdwm_pkg::ST_V2:   state_q <= fdwm_pkg::ST_M1;
				fdwm_pkg::ST_M1:   state_q <= fdwm_pkg::ST_D;
				fdwm_pkg::ST_D:    state_q <= fdwm_pkg::ST_M2;
				fdwm_pkg::ST_M2:   state_q <= fdwm_pkg::ST_FB;
				fdwm_pkg::ST_FB: begin
					state_q      <= fdwm_pkg::ST_M4;
					wp_q[ch_q]   <= (wp_cur == AW'(MAX_DELAY - 1)) ? '0 : wp_cur + 1'b1;
					if (fill_cur != MD) begin
						fill_q[ch_q] <= fill_cur + 1'b1;
					end
				end
				fdwm_pkg::ST_M4:   state_q <= fdwm_pkg::ST_MIX;
				fdwm_pkg::ST_MIX: begin
					if (out_free) begin
						state_q <= fdwm_pkg::ST_IDLE;
					end
				end
				default: state_q <= fdwm_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q  <= (CHANNELS > 1) ? s_axis_tuser : 1'b0;
			dry_q <= $signed(s_axis_tdata[SB-1:0]);
			di_q  <= dl_c[AW+7:8];
			fr_q  <= dl_c[7:0];
			fb_q  <= fb_c;
			dg_q  <= dg_c;
			wg_q  <= wg_c;
		end
		case (state_q)
			fdwm_pkg::ST_RD1: vld1_q <= tap_vld;
			fdwm_pkg::ST_RD2: begin
				vld2_q <= tap_vld;
				v1_q   <= vld1_q ? rd_s : '0;
			end
			fdwm_pkg::ST_V2: begin
				// unwritten taps read as silence
				diff_q <= (vld2_q ? (SB + 1)'(rd_s) : '0) - (SB + 1)'(v1_q);
			end
			fdwm_pkg::ST_M1: prod_q <= PW'(mul_a * mul_b);
			fdwm_pkg::ST_D:  d_q    <= interp[SB-1:0];
			fdwm_pkg::ST_M2: prod_q <= PW'(mul_a * mul_b);
			fdwm_pkg::ST_FB: prod_q <= PW'(mul_a * mul_b);
			fdwm_pkg::ST_M4: begin
				acc_q  <= prod_q;
				prod_q <= PW'(mul_a * mul_b);
			end
			fdwm_pkg::ST_MIX: if (out_free) out_q <= mixed_sat;
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'(out_q);

endmodule

// File: rtl/core/fdwm_ram.sv
`timescale 1ns / 1ps

module fdwm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: verif/fdwm_checker.sv
`timescale 1ns / 1ps

module fdwm_checker
	import fdwm_pkg::*;
#(
	parameter int MAX_DELAY   = 131072,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [CFG_ADDR_W-1:0]             cfg_addr,
	input  logic [CFG_DATA_W-1:0]             cfg_data,

	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample_in
	input  logic                              s_axis_tuser,  // channel

	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,  // sample_out

	output int                                errors,
	output int                                pending
);

	localparam int AW = $clog2(MAX_DELAY);
	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
	localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'((MAX_DELAY-1)*256);

	logic signed [SAMPLE_BITS-1:0] line_mem [0:1][0:MAX_DELAY-1];
	logic [AW-1:0]                 wr_ptr [0:1];
	logic [DELAY_W-1:0]            delay_len;
	logic [GAIN_W-1:0]             fb_gain;
	logic [GAIN_W-1:0]             dry_gain;
	logic [GAIN_W-1:0]             wet_gain;

	logic [SAMPLE_BITS-1:0]        mix_q[$];
	logic [SAMPLE_BITS-1:0]        want;

	initial begin
		errors  = 0;
		pending = 0;
		foreach (line_mem[c, a])
			line_mem[c][a] = '0;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint x);
		if (x > SAMPLE_HI)
			return SAMPLE_BITS'(SAMPLE_HI);
		if (x < SAMPLE_LO)
			return SAMPLE_BITS'(SAMPLE_LO);
		return SAMPLE_BITS'(x);
	endfunction

	// runs one sample through the line: reads the tap, writes back, returns the mix
	function automatic logic [SAMPLE_BITS-1:0] mix_sample(input logic ch,
			input logic [SAMPLE_BITS-1:0] smp);
		logic [DELAY_W-1:0]            dl;
		logic [GAIN_W-1:0]             fb, dg, wg;
		logic [AW-1:0]                 di, p1, p2, wp;
		logic [7:0]                    fr;
		longint                        dry, v1, v2, tap;
		logic signed [SAMPLE_BITS-1:0] stored;
		dl = delay_len;
		if (dl < DELAY_MIN)
			dl = DELAY_MIN;
		if (dl > DELAY_MAX)
			dl = DELAY_MAX;
		fb = (fb_gain > FB_CAP) ? FB_CAP : fb_gain;
		dg = (dry_gain > GAIN_CAP) ? GAIN_CAP : dry_gain;
		wg = (wet_gain > GAIN_CAP) ? GAIN_CAP : wet_gain;
		di = AW'(dl >> 8);
		fr = dl[7:0];
		wp = wr_ptr[ch];
		p1 = wp - di;
		p2 = wp - di - AW'(1);
		dry = longint'($signed(smp));
		v1 = longint'(line_mem[ch][p1]);
		v2 = longint'(line_mem[ch][p2]);
		// fraction blends toward the older entry, rounded, floor shift
		tap = v1 + (((v2 - v1) * longint'(fr) + 128) >>> 8);
		stored = clip(dry + ((tap * longint'(fb) + 32768) >>> 16));
		line_mem[ch][wp] = stored;
		wr_ptr[ch] = wp + AW'(1);
		return clip((dry * longint'(dg) + tap * longint'(wg) + 16384) >>> 15);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len = DELAY_RST;
			fb_gain   = FB_RST;
			dry_gain  = DRY_RST;
			wet_gain  = WET_RST;
			wr_ptr[0] = '0;
			wr_ptr[1] = '0;
			mix_q.delete();
			pending   = 0;
		end else begin
			// retire first so an item accepted this edge is not matched early
			if (m_axis_tvalid && m_axis_tready) begin
				if (mix_q.size() == 0) begin
					$error("sample_out: unexpected item, expected none, actual %0d",
						$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
					errors++;
				end else begin
					want = mix_q.pop_front();
					if (m_axis_tdata[SAMPLE_BITS-1:0] !== want) begin
						$error("sample_out: expected %0d, actual %0d", $signed(want),
							$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				mix_q.push_back(mix_sample(s_axis_tuser, s_axis_tdata[SAMPLE_BITS-1:0]));
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_DELAY_LENGTH:  delay_len = cfg_data[DELAY_W-1:0];
					CFG_FEEDBACK_GAIN: fb_gain   = cfg_data[GAIN_W-1:0];
					CFG_DRY_GAIN:      dry_gain  = cfg_data[GAIN_W-1:0];
					CFG_WET_GAIN:      wet_gain  = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			pending = mix_q.size();
		end
	end

endmodule

// File: verif/feedback_delay_wet_dry_mix_top_tb.sv
`timescale 1ns / 1ps

module feedback_delay_wet_dry_mix_top_tb;
	import fdwm_pkg::*;

	localparam int MAX_DELAY   = 131072;
	localparam int SAMPLE_BITS = 24;
	localparam int DW          = ((SAMPLE_BITS+7)/8)*8;
	localparam int LIMIT       = 600000;
	localparam int PHASE_ITEMS = 170;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DW-1:0]         s_axis_tdata;   // sample_in
	logic                  s_axis_tuser;   // channel
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DW-1:0]         m_axis_tdata;   // sample_out

	int errors;
	int pending;
	int idle_pct;
	int stall_pct;
	int cycles;

	feedback_delay_wet_dry_mix_top #(
		.MAX_DELAY  (MAX_DELAY),
		.CHANNELS   (2),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	fdwm_checker #(
		.MAX_DELAY  (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("feedback_delay_wet_dry_mix_top_tb: FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// called at a falling edge; leaves cfg_we high for a following write
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// gain registers take junk in the upper bits; only the low 16 count
	task automatic set_mix(input logic [DELAY_W-1:0] dl, input logic [GAIN_W-1:0] fb,
			input logic [GAIN_W-1:0] dg, input logic [GAIN_W-1:0] wg);
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		write_reg(CFG_DELAY_LENGTH, dl);
		write_reg(CFG_FEEDBACK_GAIN, {9'($urandom), fb});
		write_reg(CFG_DRY_GAIN, {9'($urandom), dg});
		write_reg(CFG_WET_GAIN, {9'($urandom), wg});
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic ch, input logic [SAMPLE_BITS-1:0] smp);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DW'(smp);
		s_axis_tuser  <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(19))
			0, 1:    return 24'h7FFFFF;
			2, 3:    return 24'h800000;
			4, 5:    return SAMPLE_BITS'($signed(12'($urandom)));
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [DELAY_W-1:0] dl;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cycles        = 0;
		idle_pct      = 12;
		stall_pct     = 12;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: long delay, taps still empty
		send_sample(1'b0, 24'h7FFFFF);
		send_sample(1'b1, 24'h800000);
		send_sample(1'b0, 24'h000000);
		send_sample(1'b1, 24'hFFFFFF);
		s_axis_tvalid <= 1'b0;

		// delay below one sample, feedback and gains past their caps
		set_mix(25'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (4) send_sample(1'b0, 24'h7FFFFF);
		repeat (4) send_sample(1'b1, 24'h800000);
		send_sample(1'b0, 24'h800000);
		send_sample(1'b0, 24'h800000);
		send_sample(1'b1, 24'h000001);
		send_sample(1'b0, 24'h000000);
		s_axis_tvalid <= 1'b0;

		// fraction at its top, blending two stored taps
		set_mix(25'd767, FB_CAP, GAIN_CAP, GAIN_CAP);
		repeat (3) send_sample(1'b1, 24'h400000);
		s_axis_tvalid <= 1'b0;

		// delay beyond the line, all gains zero
		set_mix(25'h1FFFFFF, 16'd0, 16'd0, 16'd0);
		send_sample(1'b0, 24'h123456);
		send_sample(1'b1, 24'hEDCBA9);
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < 10; p++) begin
			idle_pct  = (p == 5) ? 0 : 12;
			stall_pct = (p == 5) ? 0 : 12;
			case (p)
				0: set_mix(25'd256, FB_CAP, GAIN_CAP, GAIN_CAP);
				1: set_mix(25'h1FFFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
				2: set_mix(DELAY_W'((MAX_DELAY-1)*256), 16'($urandom), 16'($urandom),
						16'($urandom));
				default: begin
					if ($urandom_range(3) == 0)
						dl = DELAY_W'($urandom_range(1, 1500) * 256 + $urandom_range(255));
					else
						dl = DELAY_W'($urandom_range(1, 48) * 256 + $urandom_range(255));
					set_mix(dl, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40000)),
						16'($urandom_range(0, 40000)));
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_sample(1'($urandom), pick_sample());
			s_axis_tvalid <= 1'b0;
		end

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("feedback_delay_wet_dry_mix_top_tb: PASS");
		else
			$display("feedback_delay_wet_dry_mix_top_tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/core/fdwm_pkg.sv
rtl/core/fdwm_ram.sv
rtl/core/feedback_delay_wet_dry_mix_top.sv
verif/fdwm_checker.sv
verif/feedback_delay_wet_dry_mix_top_tb.sv
